// ===== rtl/rbh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbh_pkg: shared types, constants and helpers of the ray/box hit test
// Q16.16 word type, box request layout, divider geometry and saturation.
// ----------------------------------------------------------------------------
package rbh_pkg;

    typedef logic signed [31:0] t_q;
    typedef logic signed [32:0] t_q33;

    typedef struct packed {
        t_q box_x_min;
        t_q box_x_max;
        t_q box_y_min;
        t_q box_y_max;
        t_q box_z_min;
        t_q box_z_max;
    } t_box;

    localparam t_q Q_MAX = 32'sh7FFF_FFFF;
    localparam t_q Q_MIN = 32'sh8000_0000;
    localparam t_q Q_ONE = 32'sh0001_0000;

    // Divider: 32 quotient bits, four per stage, plus setup and output stages.
    localparam int DIV_BITS    = 32;
    localparam int DIV_PER_STG = 4;
    localparam int DIV_STAGES  = DIV_BITS / DIV_PER_STG;
    localparam int DIV_LAT     = DIV_STAGES + 2;
    // Face unit: multiply, scale, offset, slab compare.
    localparam int FACE_LAT    = 4;

    localparam int CFG_REGS = 8;
    typedef enum logic [2:0] {
        REG_ORG_X = 3'd0,
        REG_ORG_Y = 3'd1,
        REG_ORG_Z = 3'd2,
        REG_DIR_X = 3'd3,
        REG_DIR_Y = 3'd4,
        REG_DIR_Z = 3'd5,
        REG_T_MIN = 3'd6,
        REG_T_MAX = 3'd7
    } t_reg_idx;

    function automatic t_q sat_q33(input t_q33 v);
        if (v > 33'sh0_7FFF_FFFF) begin
            return Q_MAX;
        end else if (v < -33'sh0_8000_0000) begin
            return Q_MIN;
        end
        return v[31:0];
    endfunction

    // Product scale: floor shift by 16 then clamp to 32 bits.
    function automatic t_q sat_prod(input logic signed [63:0] p);
        logic signed [47:0] s;
        s = 48'(p >>> 16);
        if (s > 48'sh7FFF_FFFF) begin
            return Q_MAX;
        end else if (s < -48'sh8000_0000) begin
            return Q_MIN;
        end
        return s[31:0];
    endfunction

endpackage

// ===== rtl/rbh_box_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbh_box_if: box request channel
// Valid/ready handshake carrying one axis-aligned box.
// ----------------------------------------------------------------------------
interface rbh_box_if
    import rbh_pkg::*;
();
    logic valid;
    logic ready;
    t_box data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/rbh_hit_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbh_hit_if: hit result channel
// Valid/ready handshake carrying the one-bit hit answer.
// ----------------------------------------------------------------------------
interface rbh_hit_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, output hit, input ready);
    modport sink   (input valid, input hit, output ready);
endinterface

// ===== rtl/rbh_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbh_div: pipelined face-parameter divider
// q = (num * 2^16) / den truncated toward zero, saturated to Q16.16.
// ----------------------------------------------------------------------------
module rbh_div
    import rbh_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_q33 i_num,
    input  t_q   i_den,
    output t_q   o_q
);
    logic [31:0] w_d;
    logic [32:0] w_n;

    logic [31:0] r_r   [0:DIV_STAGES];
    logic [31:0] r_x   [0:DIV_STAGES];
    logic [31:0] r_q   [0:DIV_STAGES];
    logic        r_neg [0:DIV_STAGES];
    logic        r_ovf [0:DIV_STAGES];
    t_q          r_out;

    // Denominator is ray configuration, steady while requests are in flight.
    assign w_d = i_den[31] ? 32'(-i_den) : 32'(i_den);
    assign w_n = i_num[32] ? 33'(-i_num) : 33'(i_num);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r[0]   <= {15'd0, w_n[32:16]};
            r_x[0]   <= {w_n[15:0], 16'd0};
            r_q[0]   <= '0;
            r_neg[0] <= i_num[32] ^ i_den[31];
            r_ovf[0] <= {16'd0, w_n} >= {1'b0, w_d, 16'd0};
        end
    end

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stg
        logic [31:0] n_r, n_x, n_q;

        always_comb begin
            logic [32:0] rs;
            n_r = r_r[s];
            n_x = r_x[s];
            n_q = r_q[s];
            for (int j = 0; j < DIV_PER_STG; j++) begin
                rs  = {n_r, n_x[31]};
                n_x = {n_x[30:0], 1'b0};
                if (rs >= {1'b0, w_d}) begin
                    rs  = rs - {1'b0, w_d};
                    n_q = {n_q[30:0], 1'b1};
                end else begin
                    n_q = {n_q[30:0], 1'b0};
                end
                n_r = rs[31:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r[s+1]   <= n_r;
                r_x[s+1]   <= n_x;
                r_q[s+1]   <= n_q;
                r_neg[s+1] <= r_neg[s];
                r_ovf[s+1] <= r_ovf[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_ovf[DIV_STAGES]) begin
                r_out <= r_neg[DIV_STAGES] ? Q_MIN : Q_MAX;
            end else if (!r_neg[DIV_STAGES]) begin
                r_out <= r_q[DIV_STAGES][31] ? Q_MAX : t_q'(r_q[DIV_STAGES]);
            end else if (r_q[DIV_STAGES] > 32'h8000_0000) begin
                r_out <= Q_MIN;
            end else begin
                r_out <= t_q'(-r_q[DIV_STAGES]);
            end
        end
    end

    assign o_q = r_out;
endmodule

// ===== rtl/rbh_face.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbh_face: one box face against the ray
// Divide for t, project onto the two other axes, test the slabs.
// ----------------------------------------------------------------------------
module rbh_face
    import rbh_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_q33 i_num,
    input  t_q   i_dir_a,
    input  t_q   i_dir_b,
    input  t_q   i_dir_c,
    input  t_q   i_org_b,
    input  t_q   i_org_c,
    input  t_q   i_lo_b,
    input  t_q   i_hi_b,
    input  t_q   i_lo_c,
    input  t_q   i_hi_c,
    output logic o_cand,
    output t_q   o_t
);
    localparam int BND_DLY = DIV_LAT + FACE_LAT - 1;

    t_q w_t;
    t_q r_lob [1:BND_DLY];
    t_q r_hib [1:BND_DLY];
    t_q r_loc [1:BND_DLY];
    t_q r_hic [1:BND_DLY];

    logic signed [63:0] r_pb1, r_pc1;
    t_q   r_t1, r_pb2, r_pc2, r_t2, r_pb3, r_pc3, r_t3, r_t4;
    logic r_cand;

    rbh_div u_div (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (i_num),
        .i_den (i_dir_a),
        .o_q   (w_t)
    );

    // Hold the slab bounds alongside the divider and the projection.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lob[1] <= i_lo_b;
            r_hib[1] <= i_hi_b;
            r_loc[1] <= i_lo_c;
            r_hic[1] <= i_hi_c;
            for (int k = 2; k <= BND_DLY; k++) begin
                r_lob[k] <= r_lob[k-1];
                r_hib[k] <= r_hib[k-1];
                r_loc[k] <= r_loc[k-1];
                r_hic[k] <= r_hic[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pb1  <= i_dir_b * w_t;
            r_pc1  <= i_dir_c * w_t;
            r_t1   <= w_t;
            r_pb2  <= sat_prod(r_pb1);
            r_pc2  <= sat_prod(r_pc1);
            r_t2   <= r_t1;
            r_pb3  <= sat_q33(33'(i_org_b) + 33'(r_pb2));
            r_pc3  <= sat_q33(33'(i_org_c) + 33'(r_pc2));
            r_t3   <= r_t2;
            r_cand <= (r_lob[BND_DLY] <= r_pb3) && (r_pb3 <= r_hib[BND_DLY]) &&
                      (r_loc[BND_DLY] <= r_pc3) && (r_pc3 <= r_hic[BND_DLY]);
            r_t4   <= r_t3;
        end
    end

    assign o_cand = r_cand;
    assign o_t    = r_t4;
endmodule

// ===== rtl/ray_box_hit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_hit_test: streaming ray versus axis-aligned box hit test
// One box request per cycle against a ray held in configuration registers.
// ----------------------------------------------------------------------------
// Accepts one box every cycle and answers each with one hit bit, in order.
// The accepting edge loads the box capture register. The six face dividers
// follow, one per box face and all running in parallel. Each divider has a
// setup stage, eight stages that retire four quotient bits each, and an
// output stage. After them come four stages of projection and slab test,
// one min/max stage and the output register. A stall on the result side
// freezes the whole pipe, so the block stays at one box a cycle as long as
// the sink takes results.
// Ray registers (origin, direction, t window) must be written only while no
// request is in flight; the low-window product is refreshed through r_sprod
// and r_low_init after a write.
module ray_box_hit_test
    import rbh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  t_q         i_cfg_data,
    rbh_box_if.sink    i_box,
    rbh_hit_if.source  o_hit
);
    localparam int CAND = DIV_LAT + FACE_LAT;   // stage of face candidates
    localparam int LAST = CAND + 2;             // output register stage

    t_q   r_org [0:2];
    t_q   r_dir [0:2];
    t_q   r_tmin, r_tmax;
    logic signed [63:0] r_sprod;
    t_q   r_low_init;

    logic w_adv;
    logic r_vld    [0:LAST];
    logic r_inside [1:CAND+1];
    t_box r_box;
    t_q   w_lo [0:2];
    t_q   w_hi [0:2];

    logic w_cand [0:5];
    t_q   w_t    [0:5];
    t_q   r_low  [0:1];
    t_q   r_high [0:1];
    logic r_hit;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= '0;
            r_org[1] <= '0;
            r_org[2] <= '0;
            r_dir[0] <= Q_ONE;
            r_dir[1] <= '0;
            r_dir[2] <= '0;
            r_tmin   <= '0;
            r_tmax   <= Q_MAX;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_ORG_X: r_org[0] <= i_cfg_data;
                REG_ORG_Y: r_org[1] <= i_cfg_data;
                REG_ORG_Z: r_org[2] <= i_cfg_data;
                REG_DIR_X: r_dir[0] <= i_cfg_data;
                REG_DIR_Y: r_dir[1] <= i_cfg_data;
                REG_DIR_Z: r_dir[2] <= i_cfg_data;
                REG_T_MIN: r_tmin   <= i_cfg_data;
                REG_T_MAX: r_tmax   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Starting low: t_max * (1 + t_min), refreshed continuously.
    always_ff @(posedge i_clk) begin
        r_sprod    <= r_tmax * sat_q33(33'(Q_ONE) + 33'(r_tmin));
        r_low_init <= sat_prod(r_sprod);
    end

    // ---------------- pipeline control ----------------
    // Advance everything together when the output register is free or taken.
    assign w_adv       = !r_vld[LAST] || o_hit.ready;
    assign i_box.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAST; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[0] <= i_box.valid;
            for (int k = 1; k <= LAST; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Capture the box request.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_box <= i_box.data;
        end
    end

    assign w_lo[0] = r_box.box_x_min;
    assign w_hi[0] = r_box.box_x_max;
    assign w_lo[1] = r_box.box_y_min;
    assign w_hi[1] = r_box.box_y_max;
    assign w_lo[2] = r_box.box_z_min;
    assign w_hi[2] = r_box.box_z_max;

    // Origin inside the box answers hit outright; carry that flag along.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_inside[1] <= (w_lo[0] <= r_org[0]) && (r_org[0] <= w_hi[0]) &&
                           (w_lo[1] <= r_org[1]) && (r_org[1] <= w_hi[1]) &&
                           (w_lo[2] <= r_org[2]) && (r_org[2] <= w_hi[2]);
            for (int k = 2; k <= CAND + 1; k++) begin
                r_inside[k] <= r_inside[k-1];
            end
        end
    end

    // ---------------- face units ----------------
    // Face 2a is the lower face of axis a, face 2a+1 the upper one.
    for (genvar a = 0; a < 3; a++) begin : g_axis
        localparam int B = (a + 1) % 3;
        localparam int C = (a + 2) % 3;
        for (genvar f = 0; f < 2; f++) begin : g_side
            t_q33 w_num;
            assign w_num = f ? 33'(w_hi[a]) - 33'(r_org[a])
                             : 33'(w_lo[a]) - 33'(r_org[a]);
            rbh_face u_face (
                .i_clk   (i_clk),
                .i_en    (w_adv),
                .i_num   (w_num),
                .i_dir_a (r_dir[a]),
                .i_dir_b (r_dir[B]),
                .i_dir_c (r_dir[C]),
                .i_org_b (r_org[B]),
                .i_org_c (r_org[C]),
                .i_lo_b  (w_lo[B]),
                .i_hi_b  (w_hi[B]),
                .i_lo_c  (w_lo[C]),
                .i_hi_c  (w_hi[C]),
                .o_cand  (w_cand[2*a+f]),
                .o_t     (w_t[2*a+f])
            );
        end
    end

    // ---------------- min/max reduction ----------------
    // Group 0 takes the x faces and the lower y face and starts from the
    // window sentinel; group 1 takes the upper y face and the z faces and
    // starts neutral. Drop faces of a zero axis.
    always_ff @(posedge i_clk) begin
        t_q lo_v, hi_v;
        if (w_adv) begin
            for (int g = 0; g < 2; g++) begin
                lo_v = (g == 0) ? r_low_init : Q_MAX;
                hi_v = '0;
                for (int j = 0; j < 3; j++) begin
                    if (w_cand[3*g+j] && (r_dir[(3*g+j)/2] != '0)) begin
                        if (w_t[3*g+j] < lo_v) begin
                            lo_v = w_t[3*g+j];
                        end
                        if (w_t[3*g+j] > hi_v) begin
                            hi_v = w_t[3*g+j];
                        end
                    end
                end
                r_low[g]  <= lo_v;
                r_high[g] <= hi_v;
            end
        end
    end

    // Final verdict into the output register.
    always_ff @(posedge i_clk) begin
        t_q lo_v, hi_v;
        if (w_adv) begin
            lo_v  = (r_low[0] < r_low[1]) ? r_low[0] : r_low[1];
            hi_v  = (r_high[0] > r_high[1]) ? r_high[0] : r_high[1];
            r_hit <= r_inside[CAND+1] || ((hi_v >= r_tmin) && (lo_v <= r_tmax));
        end
    end

    assign o_hit.valid = r_vld[LAST];
    assign o_hit.hit   = r_hit;

`ifndef NO_ASSERTIONS
    // An accepted request shows up in the first stage.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_box.valid && i_box.ready |=> r_vld[0])
        else $error("accepted box request lost at entry");

    // Back-pressure only comes from a held result.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_box.ready |-> o_hit.valid)
        else $error("input stalled with no result waiting");

    // An origin inside the box must always report a hit.
    a_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_vld[CAND+1] && r_inside[CAND+1] |=> o_hit.valid && o_hit.hit)
        else $error("origin inside box reported as miss");
`endif
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the ray/box hit test
// Streams boxes against a series of rays, predicts each hit bit in Q16.16
// integer math and compares it against the block's in-order answers.
// ----------------------------------------------------------------------------
module testbench;
    import rbh_pkg::*;

    localparam int PIPE_DRAIN = 40;      // longer than the block's pipeline
    localparam int CYCLE_LIMIT = 400000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [2:0] i_cfg_idx;
    t_q         i_cfg_data;

    rbh_box_if box_if ();
    rbh_hit_if hit_if ();

    ray_box_hit_test dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_box      (box_if.sink),
        .o_hit      (hit_if.source)
    );

    // Local copy of the ray registers, kept in step with every write.
    t_q ray_org [3];
    t_q ray_dir [3];
    t_q win_lo;
    t_q win_hi;

    t_box pending_boxes [$];   // requests waiting for the driver
    logic hit_expect    [$];   // predicted answers, oldest first
    int   err_count;
    int   cycle_count;
    logic box_taken;

    // ------------------------------------------------------------------
    // Predictor: Q16.16 math with saturation, done in 64-bit integers.
    // ------------------------------------------------------------------
    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        longint p;
        p = a * b;
        return clamp32(p >>> 16);   // floor shift
    endfunction

    function automatic longint fx_div(longint num, longint den);
        return clamp32((num * 65536) / den);   // truncates toward zero
    endfunction

    function automatic logic predict_hit(t_box b);
        longint o [3];
        longint d [3];
        longint lo [3];
        longint hi [3];
        longint low, high, t, pb, pc, face;
        int ax, bx, cx;
        o[0] = ray_org[0]; o[1] = ray_org[1]; o[2] = ray_org[2];
        d[0] = ray_dir[0]; d[1] = ray_dir[1]; d[2] = ray_dir[2];
        lo[0] = b.box_x_min; hi[0] = b.box_x_max;
        lo[1] = b.box_y_min; hi[1] = b.box_y_max;
        lo[2] = b.box_z_min; hi[2] = b.box_z_max;
        // Origin inside the box (inclusive) is a hit outright.
        if (lo[0] <= o[0] && o[0] <= hi[0] && lo[1] <= o[1] && o[1] <= hi[1] &&
            lo[2] <= o[2] && o[2] <= hi[2]) begin
            return 1'b1;
        end
        low  = fx_mul(longint'(win_hi), clamp32(65536 + longint'(win_lo)));
        high = 0;
        // Axis order x, z, y; each with its two in-plane companions.
        for (int k = 0; k < 3; k++) begin
            ax = (k == 0) ? 0 : (k == 1) ? 2 : 1;
            bx = (k == 0) ? 1 : (k == 1) ? 0 : 2;
            cx = (k == 0) ? 2 : (k == 1) ? 1 : 0;
            if (d[ax] != 0) begin
                for (int f = 0; f < 2; f++) begin
                    face = f ? hi[ax] : lo[ax];
                    t  = fx_div(face - o[ax], d[ax]);
                    pb = clamp32(o[bx] + fx_mul(d[bx], t));
                    pc = clamp32(o[cx] + fx_mul(d[cx], t));
                    if (lo[bx] <= pb && pb <= hi[bx] && lo[cx] <= pc && pc <= hi[cx]) begin
                        if (t < low) low = t;
                        if (t > high) high = t;
                    end
                end
            end
        end
        return (high >= longint'(win_lo)) && (low <= longint'(win_hi));
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side: note each accepted request and predict its answer.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        box_taken <= box_if.valid && box_if.ready;
        if (i_rst_n && box_if.valid && box_if.ready) begin
            hit_expect.push_back(predict_hit(box_if.data));
        end
    end

    // Driver: bursts of random length separated by random gaps.
    int burst_left;
    int gap_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            box_if.valid <= 1'b0;
        end else if (!box_if.valid || box_taken) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                box_if.valid <= 1'b0;
            end else if (pending_boxes.size() > 0) begin
                box_if.data  <= pending_boxes.pop_front();
                box_if.valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    // no gap at all in some stretches
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                box_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: stall on a pattern that changes mode now and then.
    // ------------------------------------------------------------------
    int stall_mode;
    int mode_left;
    int phase_ctr;
    always @(negedge i_clk) begin
        phase_ctr <= phase_ctr + 1;
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(50, 300);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: begin
                hit_if.ready <= 1'b1;
            end
            1: begin
                hit_if.ready <= $urandom_range(0, 1);
            end
            2: begin
                hit_if.ready <= ($urandom_range(0, 7) != 0);
            end
            default: begin
                hit_if.ready <= (phase_ctr % 5) < 2;
            end
        endcase
    end

    // Compare each answer with the oldest prediction.
    always @(posedge i_clk) begin
        logic want;
        if (i_rst_n && hit_if.valid && hit_if.ready) begin
            if (hit_expect.size() == 0) begin
                report_mismatch($sformatf("unexpected answer hit=%0b", hit_if.hit));
            end else begin
                want = hit_expect.pop_front();
                if (hit_if.hit !== want) begin
                    report_mismatch($sformatf("hit=%0b, predicted %0b", hit_if.hit, want));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_q rand_span(int unsigned span);
        return t_q'(int'($urandom_range(0, 2 * span)) - int'(span));
    endfunction

    // Mostly moderate values, sometimes raw 32-bit words or the extremes.
    function automatic t_q rand_coord(int unsigned span);
        case ($urandom_range(0, 15))
            0: return t_q'($urandom);
            1: return Q_MAX;
            2: return Q_MIN;
            default: return rand_span(span);
        endcase
    endfunction

    task automatic write_reg(t_reg_idx idx, t_q val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_ORG_X: ray_org[0] = val;
            REG_ORG_Y: ray_org[1] = val;
            REG_ORG_Z: ray_org[2] = val;
            REG_DIR_X: ray_dir[0] = val;
            REG_DIR_Y: ray_dir[1] = val;
            REG_DIR_Z: ray_dir[2] = val;
            REG_T_MIN: win_lo = val;
            default:   win_hi = val;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_ray(t_q ox, t_q oy, t_q oz, t_q dx, t_q dy, t_q dz,
                            t_q tlo, t_q thi);
        write_reg(REG_ORG_X, ox);
        write_reg(REG_ORG_Y, oy);
        write_reg(REG_ORG_Z, oz);
        write_reg(REG_DIR_X, dx);
        write_reg(REG_DIR_Y, dy);
        write_reg(REG_DIR_Z, dz);
        write_reg(REG_T_MIN, tlo);
        write_reg(REG_T_MAX, thi);
        // let the low-window product settle
        repeat (4) @(negedge i_clk);
    endtask

    function automatic t_q rand_dir();
        case ($urandom_range(0, 9))
            0, 1: return '0;                 // axis drops out
            2: return ($urandom_range(0, 1)) ? Q_MAX : Q_MIN;
            3: return ($urandom_range(0, 1)) ? 32'sd1 : -32'sd1;
            default: return rand_span(3 << 16);
        endcase
    endfunction

    // Box built around a point of the current ray, so faces often get hit.
    function automatic t_box box_near_ray();
        t_box   b;
        t_q     lo [3];
        t_q     hi [3];
        longint tt, p, e0, e1;
        tt = rand_span(6 << 16);
        for (int a = 0; a < 3; a++) begin
            p  = clamp32(longint'(ray_org[a]) + fx_mul(ray_dir[a], tt));
            e0 = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 4 << 16);
            e1 = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 4 << 16);
            lo[a] = t_q'(clamp32(p - e0));
            hi[a] = t_q'(clamp32(p + e1));
            case ($urandom_range(0, 15))
                0: begin
                    lo[a] = hi[a] + t_q'($urandom_range(1, 1 << 16));   // inverted slab
                end
                1: begin
                    lo[a] = t_q'($urandom);
                    hi[a] = t_q'($urandom);
                end
                2: begin
                    lo[a] = Q_MIN;
                    hi[a] = Q_MAX;
                end
                default: begin
                end
            endcase
        end
        b.box_x_min = lo[0]; b.box_x_max = hi[0];
        b.box_y_min = lo[1]; b.box_y_max = hi[1];
        b.box_z_min = lo[2]; b.box_z_max = hi[2];
        return b;
    endfunction

    function automatic t_box mk_box(t_q x0, t_q x1, t_q y0, t_q y1, t_q z0, t_q z1);
        t_box b;
        b.box_x_min = x0; b.box_x_max = x1;
        b.box_y_min = y0; b.box_y_max = y1;
        b.box_z_min = z0; b.box_z_max = z1;
        return b;
    endfunction

    // Check at the rising edge, where the driver's queue and valid are settled.
    task automatic wait_drained();
        while (pending_boxes.size() > 0 || box_if.valid || hit_expect.size() > 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic push_random(int n);
        t_box b;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                b = t_box'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
            end else begin
                b = box_near_ray();
            end
            pending_boxes.push_back(b);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        t_q one;
        one = Q_ONE;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        box_if.valid = 1'b0;
        box_if.data  = '0;
        hit_if.ready = 1'b0;
        box_taken    = 1'b0;
        err_count    = 0;
        cycle_count  = 0;
        burst_left   = 1;
        gap_left     = 0;
        stall_mode   = 0;
        mode_left    = 0;
        phase_ctr    = 0;
        // reset values of the ray registers
        ray_org[0] = '0; ray_org[1] = '0; ray_org[2] = '0;
        ray_dir[0] = Q_ONE; ray_dir[1] = '0; ray_dir[2] = '0;
        win_lo = '0;
        win_hi = Q_MAX;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed boxes against the reset ray (+x from the origin).
        pending_boxes.push_back(mk_box(-one, one, -one, one, -one, one));      // origin inside
        pending_boxes.push_back(mk_box('0, one, '0, one, '0, one));            // origin on corner
        pending_boxes.push_back(mk_box(2 * one, 3 * one, -one, one, -one, one)); // ahead
        pending_boxes.push_back(mk_box(-3 * one, -2 * one, -one, one, -one, one)); // behind
        pending_boxes.push_back(mk_box(2 * one, 3 * one, one, 2 * one, -one, one)); // beside
        pending_boxes.push_back(mk_box(2 * one, 3 * one, '0, '0, '0, '0));      // flat slabs
        pending_boxes.push_back(mk_box(3 * one, 2 * one, -one, one, -one, one)); // inverted x
        pending_boxes.push_back(mk_box(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX));
        pending_boxes.push_back(mk_box(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        pending_boxes.push_back(mk_box(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        pending_boxes.push_back(mk_box(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
        pending_boxes.push_back(mk_box(one, Q_MAX, Q_MIN, Q_MAX, '0, '0));
        pending_boxes.push_back(mk_box('1, '1, '1, '1, '1, '1));
        wait_drained();

        // Extreme rays: saturating directions and windows.
        load_ray(Q_MIN, Q_MAX, '0, Q_MAX, Q_MIN, 32'sd1, Q_MIN, Q_MAX);
        pending_boxes.push_back(mk_box(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX));
        pending_boxes.push_back(mk_box('0, one, '0, one, '0, one));
        pending_boxes.push_back(mk_box(Q_MAX, Q_MAX, Q_MIN, Q_MIN, '0, '0));
        push_random(150);
        wait_drained();

        load_ray(Q_MAX, Q_MIN, Q_MAX, Q_MIN, '0, Q_MAX, Q_MAX, Q_MIN);
        push_random(150);
        wait_drained();

        // Zero window at t = 0: the low start is then zero, so every box is a hit.
        load_ray('0, '0, '0, one, one, '0, '0, '0);
        push_random(150);
        wait_drained();

        // Random rays; one phase holds off the sender halfway until drained.
        for (int ph = 0; ph < 10; ph++) begin
            load_ray(rand_coord(8 << 16), rand_coord(8 << 16), rand_coord(8 << 16),
                     rand_dir(), rand_dir(), rand_dir(),
                     ($urandom_range(0, 3) == 0) ? rand_coord(4 << 16)
                                                 : t_q'($urandom_range(0, 1 << 16)),
                     ($urandom_range(0, 3) == 0) ? rand_coord(16 << 16)
                                                 : t_q'($urandom_range(1 << 16, 12 << 16)));
            push_random(75);
            if (ph == 3) begin
                wait_drained();
            end
            push_random(75);
            wait_drained();
        end

        repeat (PIPE_DRAIN) @(negedge i_clk);
        if (err_count == 0 && hit_expect.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
